@@ design/krv_pkg.sv @@
// Shared types and constants for the Kepler radial-velocity solver.
// Holds the sequencer state codes, job pass codes, register indexes and the CORDIC table.
// No dependencies.
package krv_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_MEAN, S_MADD, S_LIM, S_LIMW, S_CORD, S_ROT, S_EU1, S_EU2, S_EU3,
    S_LOOP, S_DEN, S_DENW, S_DIV, S_QUO, S_SQM, S_SQL, S_SQRT,
    S_FM1, S_FM2, S_FM3, S_FM4, S_FM5, S_FM6, S_OUT
  } state_t;

  // What a finished CORDIC rotation feeds
  typedef enum logic [1:0] {
    PASS_INIT, PASS_NEWTON, PASS_FINAL, PASS_VARPI
  } pass_t;

  // Configuration register indexes
  localparam logic [2:0] REG_AMPLITUDE   = 3'd0;
  localparam logic [2:0] REG_ANG_SPEED   = 3'd1;
  localparam logic [2:0] REG_PHASE       = 3'd2;
  localparam logic [2:0] REG_ECC         = 3'd3;
  localparam logic [2:0] REG_PERIAPSIS   = 3'd4;
  localparam logic [2:0] REG_TOLERANCE   = 3'd5;

  localparam logic [15:0] TOL_RESET = 16'd43;

  // Fixed-point constants (Q30 ratios, binary-turn angles)
  localparam logic signed [33:0] ONE30       = 34'sd1073741824;
  localparam logic signed [33:0] RAD_UNITS   = 34'sd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] HALF_TURN   = 34'sd2147483648;

  // Arctangent of 2^-i in binary-turn units
  function automatic logic [31:0] atan_units(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h20000000;
      6'd1:  v = 32'h12E4051E;
      6'd2:  v = 32'h09FB385B;
      6'd3:  v = 32'h051111D4;
      6'd4:  v = 32'h028B0D43;
      6'd5:  v = 32'h0145D7E1;
      6'd6:  v = 32'h00A2F61E;
      6'd7:  v = 32'h00517C55;
      6'd8:  v = 32'h0028BE53;
      6'd9:  v = 32'h00145F2F;
      6'd10: v = 32'h000A2F98;
      6'd11: v = 32'h000517CC;
      6'd12: v = 32'h00028BE6;
      6'd13: v = 32'h000145F3;
      6'd14: v = 32'h0000A2FA;
      6'd15: v = 32'h0000517D;
      6'd16: v = 32'h000028BE;
      6'd17: v = 32'h0000145F;
      6'd18: v = 32'h00000A30;
      6'd19: v = 32'h00000518;
      6'd20: v = 32'h0000028C;
      6'd21: v = 32'h00000146;
      6'd22: v = 32'h000000A3;
      6'd23: v = 32'h00000051;
      6'd24: v = 32'h00000029;
      6'd25: v = 32'h00000014;
      6'd26: v = 32'h0000000A;
      6'd27: v = 32'h00000005;
      6'd28: v = 32'h00000003;
      6'd29: v = 32'h00000001;
      6'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ design/kepler_radial_velocity.sv @@
// Kepler radial-velocity predictor: one iterative datapath under a sequencer.
// A shared 34x34 multiplier, a CORDIC rotator, a radix-2 divider and a bit-pair square root.
// Depends on krv_pkg.
// Work per sample grows with N, the Newton steps taken (0 to MAX_ITERATIONS); each step
// is one CORDIC pass, a divide and multiplier products. One sample at a time:
// in_stall stays high until the sample finishes.
// Reset (synchronous, rst_n low) clears the sequencer and output valid and restores the
// configuration registers to their reset values; no clearing pass.
module kepler_radial_velocity #(
  parameter int MAX_ITERATIONS = 32,
  parameter int CORDIC_STEPS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_radial_velocity,
  output logic               out_converged,
  output logic [6:0]         out_iterations_used
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] CK_LAST  = CW'(CORDIC_STEPS - 1);
  localparam logic [6:0]    ITER_CAP = 7'(MAX_ITERATIONS);

  // Configuration registers
  logic signed [31:0] amp_r, aspeed_r;
  logic [31:0]        phase_r, varpi_r;
  logic [15:0]        ecc_r, tol_r;

  // Sequencer
  krv_pkg::state_t state_r, state_nxt;
  krv_pkg::pass_t  pass_r, pass_nxt;

  // Datapath registers
  logic signed [31:0] t_r, t_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [47:0]        limit_r, limit_nxt;
  logic signed [33:0] lo_r, lo_nxt;
  logic signed [67:0] prod_r, prod_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic               flip_r, flip_nxt;
  logic [CW-1:0]      ck_r, ck_nxt;
  logic signed [33:0] s_r, s_nxt, c_r, c_nxt;
  logic signed [36:0] e_r, e_nxt;
  logic signed [37:0] delta_r, delta_nxt;
  logic [6:0]         iters_r, iters_nxt;
  logic               conv_r, conv_nxt;
  logic [31:0]        den_r, den_nxt, rem_r, rem_nxt;
  logic [63:0]        quo_r, quo_nxt;
  logic               neg_r, neg_nxt;
  logic [5:0]         dk_r, dk_nxt;
  logic signed [33:0] cf_r, cf_nxt, sf_r, sf_nxt;
  logic [60:0]        sqv_r, sqv_nxt, sqbit_r, sqbit_nxt;
  logic [61:0]        sqr_r, sqr_nxt;
  logic signed [67:0] acc_r, acc_nxt;
  logic signed [33:0] sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_rv_r, out_rv_nxt;
  logic               out_conv_r, out_conv_nxt;
  logic [6:0]         out_iter_r, out_iter_nxt;

  logic signed [33:0] mul_a, mul_b, ecc_s;

  assign ecc_s    = $signed({18'b0, ecc_r});
  assign in_stall = (state_r != krv_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_radial_velocity = out_rv_r;
  assign out_converged       = out_conv_r;
  assign out_iterations_used = out_iter_r;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r    <= '0;
      aspeed_r <= '0;
      phase_r  <= '0;
      ecc_r    <= '0;
      varpi_r  <= '0;
      tol_r    <= krv_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        krv_pkg::REG_AMPLITUDE: amp_r    <= cfg_data;
        krv_pkg::REG_ANG_SPEED: aspeed_r <= cfg_data;
        krv_pkg::REG_PHASE:     phase_r  <= cfg_data;
        krv_pkg::REG_ECC:       ecc_r    <= cfg_data[15:0];
        krv_pkg::REG_PERIAPSIS: varpi_r  <= cfg_data;
        krv_pkg::REG_TOLERANCE: tol_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Route operands to the shared multiplier; product lands in prod_r next cycle
  always_comb begin
    case (state_r)
      krv_pkg::S_MEAN: begin mul_a = 34'(aspeed_r); mul_b = 34'(t_r); end
      krv_pkg::S_LIM:  begin mul_a = $signed({18'b0, tol_r}); mul_b = $signed({2'b0, m_r}); end
      krv_pkg::S_EU1:  begin mul_a = ecc_s; mul_b = s_r; end
      krv_pkg::S_EU2:  begin mul_a = 34'(prod_r >>> 16); mul_b = krv_pkg::RAD_UNITS; end
      krv_pkg::S_DEN:  begin mul_a = ecc_s; mul_b = c_r; end
      krv_pkg::S_SQM:  begin mul_a = cf_r; mul_b = cf_r; end
      krv_pkg::S_FM1:  begin mul_a = sf_r; mul_b = c_r; end
      krv_pkg::S_FM2:  begin mul_a = cf_r; mul_b = s_r; end
      krv_pkg::S_FM3:  begin mul_a = ecc_s; mul_b = s_r; end
      krv_pkg::S_FM5:  begin mul_a = 34'(amp_r); mul_b = sum_r; end
      default:         begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Next state and datapath updates
  always_comb begin
    logic               start_cord;
    logic [31:0]        cang, cang_q, cang_z;
    logic signed [33:0] eu, dd, hi;
    logic signed [34:0] cdiff;
    logic signed [63:0] num, q, ep;
    logic [32:0]        trial;
    logic [61:0]        sq_try;
    logic [37:0]        ad;
    logic signed [67:0] facc;
    logic signed [37:0] vsat;

    start_cord = 1'b0;
    cang   = '0;
    eu     = 34'(prod_r >>> 30);
    hi     = lo_r + krv_pkg::HALF_TURN;
    dd     = krv_pkg::ONE30 - 34'(prod_r >>> 16);
    cdiff  = 35'(c_r) - $signed({5'b0, ecc_r, 14'b0});
    q      = neg_r ? -$signed(quo_r) : $signed(quo_r);
    ep     = 64'(e_r) + q;
    trial  = {rem_r, quo_r[63]};
    sq_try = sqr_r + {1'b0, sqbit_r};
    ad     = delta_r[37] ? 38'(-delta_r) : 38'(delta_r);
    facc   = acc_r + prod_r;
    vsat   = 38'(prod_r >>> 30);
    num    = '0;

    state_nxt = state_r;
    pass_nxt  = pass_r;
    t_nxt = t_r; m_nxt = m_r; limit_nxt = limit_r; lo_nxt = lo_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; flip_nxt = flip_r; ck_nxt = ck_r;
    s_nxt = s_r; c_nxt = c_r; e_nxt = e_r; delta_nxt = delta_r;
    iters_nxt = iters_r; conv_nxt = conv_r;
    den_nxt = den_r; rem_nxt = rem_r; quo_nxt = quo_r; neg_nxt = neg_r; dk_nxt = dk_r;
    cf_nxt = cf_r; sf_nxt = sf_r; sqv_nxt = sqv_r; sqr_nxt = sqr_r; sqbit_nxt = sqbit_r;
    acc_nxt = acc_r; sum_nxt = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rv_nxt = out_rv_r; out_conv_nxt = out_conv_r; out_iter_nxt = out_iter_r;

    case (state_r)
      // Take one input beat
      krv_pkg::S_IDLE: begin
        if (in_valid) begin
          t_nxt     = in_sample_time;
          state_nxt = krv_pkg::S_MEAN;
        end
      end
      krv_pkg::S_MEAN: state_nxt = krv_pkg::S_MADD;
      // Wrap mean anomaly; zero anomaly skips the solver
      krv_pkg::S_MADD: begin
        m_nxt     = prod_r[46:15] + phase_r;
        lo_nxt    = m_nxt[31] ? krv_pkg::HALF_TURN : '0;
        iters_nxt = '0;
        if (m_nxt == '0) begin
          e_nxt      = '0;
          conv_nxt   = 1'b1;
          start_cord = 1'b1;
          pass_nxt   = krv_pkg::PASS_FINAL;
        end else begin
          conv_nxt  = 1'b0;
          state_nxt = krv_pkg::S_LIM;
        end
      end
      krv_pkg::S_LIM: state_nxt = krv_pkg::S_LIMW;
      krv_pkg::S_LIMW: begin
        limit_nxt  = prod_r[47:0];
        cang       = m_r;
        start_cord = 1'b1;
        pass_nxt   = krv_pkg::PASS_INIT;
      end
      // Advance one CORDIC micro-rotation
      krv_pkg::S_CORD: begin
        if (!cz_r[33]) begin
          cx_nxt = cx_r - (cy_r >>> ck_r);
          cy_nxt = cy_r + (cx_r >>> ck_r);
          cz_nxt = cz_r - $signed({2'b0, krv_pkg::atan_units(6'(ck_r))});
        end else begin
          cx_nxt = cx_r + (cy_r >>> ck_r);
          cy_nxt = cy_r - (cx_r >>> ck_r);
          cz_nxt = cz_r + $signed({2'b0, krv_pkg::atan_units(6'(ck_r))});
        end
        ck_nxt = ck_r + 1'b1;
        if (ck_r == CK_LAST) state_nxt = krv_pkg::S_ROT;
      end
      // Undo the half-turn fold and dispatch the sine/cosine
      krv_pkg::S_ROT: begin
        s_nxt = flip_r ? -cy_r : cy_r;
        c_nxt = flip_r ? -cx_r : cx_r;
        case (pass_r)
          krv_pkg::PASS_INIT, krv_pkg::PASS_NEWTON: state_nxt = krv_pkg::S_EU1;
          krv_pkg::PASS_FINAL: state_nxt = krv_pkg::S_DEN;
          default: state_nxt = krv_pkg::S_FM1;
        endcase
      end
      krv_pkg::S_EU1: state_nxt = krv_pkg::S_EU2;
      krv_pkg::S_EU2: state_nxt = krv_pkg::S_EU3;
      // e*sin in angle units: first guess or Newton residual
      krv_pkg::S_EU3: begin
        if (pass_r == krv_pkg::PASS_INIT) begin
          e_nxt     = $signed({5'b0, m_r}) + 37'(eu);
          state_nxt = krv_pkg::S_LOOP;
        end else begin
          delta_nxt = $signed({6'b0, m_r}) - 38'(e_r) + 38'(eu);
          state_nxt = krv_pkg::S_DEN;
        end
      end
      // Decide on another Newton step
      krv_pkg::S_LOOP: begin
        cang       = e_r[31:0];
        start_cord = 1'b1;
        pass_nxt   = (iters_r < ITER_CAP && !conv_r) ? krv_pkg::PASS_NEWTON
                                                     : krv_pkg::PASS_FINAL;
      end
      krv_pkg::S_DEN: state_nxt = krv_pkg::S_DENW;
      // Clamp denominator and load the divider with the magnitude
      krv_pkg::S_DENW: begin
        den_nxt = (dd < 34'sd1) ? 32'd1 : 32'(dd);
        if (pass_r == krv_pkg::PASS_NEWTON) num = 64'(delta_r) <<< 30;
        else                                num = 64'(cdiff) <<< 30;
        neg_nxt   = num[63];
        quo_nxt   = num[63] ? 64'(-num) : 64'(num);
        rem_nxt   = '0;
        dk_nxt    = '0;
        state_nxt = krv_pkg::S_DIV;
      end
      // One quotient bit per cycle
      krv_pkg::S_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = 32'(trial - {1'b0, den_r});
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        dk_nxt = dk_r + 1'b1;
        if (dk_r == 6'd63) state_nxt = krv_pkg::S_QUO;
      end
      // Apply quotient: Newton update with bracket, or true-anomaly cosine
      krv_pkg::S_QUO: begin
        if (pass_r == krv_pkg::PASS_NEWTON) begin
          if (ep < 64'(lo_r))      e_nxt = (e_r + 37'(lo_r)) >>> 1;
          else if (ep > 64'(hi))   e_nxt = (e_r + 37'(hi)) >>> 1;
          else                     e_nxt = 37'(ep);
          iters_nxt = iters_r + 1'b1;
          conv_nxt  = (ad < 38'd65536) && ({ad[15:0], 32'b0} <= limit_r);
          state_nxt = krv_pkg::S_LOOP;
        end else begin
          if (q > 64'(krv_pkg::ONE30))       cf_nxt = krv_pkg::ONE30;
          else if (q < -64'(krv_pkg::ONE30)) cf_nxt = -krv_pkg::ONE30;
          else                               cf_nxt = 34'(q);
          state_nxt = krv_pkg::S_SQM;
        end
      end
      krv_pkg::S_SQM: state_nxt = krv_pkg::S_SQL;
      krv_pkg::S_SQL: begin
        sqv_nxt   = 61'h1000000000000000 - prod_r[60:0];
        sqr_nxt   = '0;
        sqbit_nxt = 61'h1000000000000000;
        state_nxt = krv_pkg::S_SQRT;
      end
      // One result bit per cycle; sign follows sin E
      krv_pkg::S_SQRT: begin
        if ({1'b0, sqv_r} >= sq_try) begin
          sqv_nxt = 61'({1'b0, sqv_r} - sq_try);
          sqr_nxt = (sqr_r >> 1) + {1'b0, sqbit_r};
        end else begin
          sqr_nxt = sqr_r >> 1;
        end
        sqbit_nxt = sqbit_r >> 2;
        if (sqbit_r[0]) begin
          sf_nxt     = s_r[33] ? -$signed({3'b0, sqr_nxt[30:0]})
                               : $signed({3'b0, sqr_nxt[30:0]});
          cang       = varpi_r;
          start_cord = 1'b1;
          pass_nxt   = krv_pkg::PASS_VARPI;
        end
      end
      krv_pkg::S_FM1: state_nxt = krv_pkg::S_FM2;
      krv_pkg::S_FM2: begin
        acc_nxt   = prod_r;
        state_nxt = krv_pkg::S_FM3;
      end
      krv_pkg::S_FM3: begin
        sum_nxt   = 34'(facc >>> 30);
        state_nxt = krv_pkg::S_FM4;
      end
      krv_pkg::S_FM4: begin
        sum_nxt   = sum_r + 34'(prod_r >>> 16);
        state_nxt = krv_pkg::S_FM5;
      end
      krv_pkg::S_FM5: state_nxt = krv_pkg::S_FM6;
      // Scale by amplitude and saturate
      krv_pkg::S_FM6: begin
        if (vsat > 38'sd2147483647)       out_rv_nxt = 32'sh7FFFFFFF;
        else if (vsat < -38'sd2147483648) out_rv_nxt = 32'sh80000000;
        else                              out_rv_nxt = 32'(vsat);
        state_nxt = krv_pkg::S_OUT;
      end
      // Hold until the output register is free
      krv_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_conv_nxt  = conv_r;
          out_iter_nxt  = iters_r;
          state_nxt     = krv_pkg::S_IDLE;
        end
      end
      default: state_nxt = krv_pkg::S_IDLE;
    endcase

    // Start a CORDIC pass, folding the angle into the right half-plane
    if (start_cord) begin
      cang_q    = cang + 32'h40000000;
      cang_z    = cang_q[31] ? cang - 32'h80000000 : cang;
      flip_nxt  = cang_q[31];
      cx_nxt    = krv_pkg::CORDIC_GAIN;
      cy_nxt    = '0;
      cz_nxt    = 34'($signed(cang_z));
      ck_nxt    = '0;
      state_nxt = krv_pkg::S_CORD;
    end else begin
      cang_q = '0;
      cang_z = '0;
    end
  end

  // State register and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krv_pkg::S_IDLE;
      pass_r      <= krv_pkg::PASS_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r <= t_nxt; m_r <= m_nxt; limit_r <= limit_nxt; lo_r <= lo_nxt;
    prod_r <= prod_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; flip_r <= flip_nxt; ck_r <= ck_nxt;
    s_r <= s_nxt; c_r <= c_nxt; e_r <= e_nxt; delta_r <= delta_nxt;
    iters_r <= iters_nxt; conv_r <= conv_nxt;
    den_r <= den_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; neg_r <= neg_nxt; dk_r <= dk_nxt;
    cf_r <= cf_nxt; sf_r <= sf_nxt; sqv_r <= sqv_nxt; sqr_r <= sqr_nxt; sqbit_r <= sqbit_nxt;
    acc_r <= acc_nxt; sum_r <= sum_nxt;
    out_rv_r <= out_rv_nxt; out_conv_r <= out_conv_nxt; out_iter_r <= out_iter_nxt;
  end

  // A result that missed tolerance has used every Newton step
  a_cap_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_conv_r |-> out_iter_r == ITER_CAP)
    else $error("unconverged beat without full iteration count");

  // Step count never exceeds the cap
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_iter_r <= ITER_CAP)
    else $error("iteration count above cap");

  // Divider never runs on a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == krv_pkg::S_DIV |-> den_r != '0)
    else $error("zero divisor in divider");

endmodule
